@@ rtl/tsef_pkg.sv @@
// ----------------------------------------------------------------------------
// tsef_pkg
// shared types and constants for the track start edge finder
// ----------------------------------------------------------------------------
package tsef_pkg;

   // image geometry
   localparam int IMAGE_WIDTH = 188;

   localparam logic [7:0] LEFT_PAIR_COL     = 8'd2;
   localparam logic [7:0] LEFT_BORDER_EDGE  = 8'd1;
   localparam logic [7:0] RIGHT_BORDER_COL  = 8'(IMAGE_WIDTH - 2);
   localparam logic [7:0] LAST_COL          = 8'(IMAGE_WIDTH - 1);
   localparam logic [7:0] PATTERN_FIRST_COL = 8'd4;
   localparam logic [7:0] PATTERN_OFFSET    = 8'd3;
   localparam logic [7:0] COL_MAX           = 8'hFF;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_MIN_TRACK_WIDTH = 2'd0,
      CSR_WHITE_LEVEL     = 2'd1,
      CSR_BLACK_LEVEL     = 2'd2,
      CSR_UNUSED          = 2'd3
   } csr_index_type;

   localparam logic [7:0] MIN_TRACK_WIDTH_RST = 8'd10;
   localparam logic [7:0] WHITE_LEVEL_RST     = 8'd255;
   localparam logic [7:0] BLACK_LEVEL_RST     = 8'd0;

   typedef struct packed {
      logic [7:0] min_track_width;
      logic [7:0] white_level;
      logic [7:0] black_level;
   } cfg_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic [7:0] row_index;
      logic       end_of_row;
      logic       new_search;
   } req_item_type;

   typedef struct packed {
      logic [7:0] left_col;
      logic [7:0] right_col;
      logic [7:0] edge_row;
      logic       left_seen;
      logic       right_seen;
      logic       start_found;
   } rsp_item_type;

endpackage

@@ rtl/tsef_if.sv @@
// ----------------------------------------------------------------------------
// tsef channel interfaces
// valid/ready channels for pixel beats and row result beats
// ----------------------------------------------------------------------------
interface tsef_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic [7:0] row_index;
   logic       end_of_row;
   logic       new_search;

   modport source (output valid, pixel, row_index, end_of_row, new_search,
                   input ready);
   modport sink   (input valid, pixel, row_index, end_of_row, new_search,
                   output ready);
endinterface

interface tsef_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] left_col;
   logic [7:0] right_col;
   logic [7:0] edge_row;
   logic       left_seen;
   logic       right_seen;
   logic       start_found;

   modport source (output valid, left_col, right_col, edge_row, left_seen,
                   right_seen, start_found, input ready);
   modport sink   (input valid, left_col, right_col, edge_row, left_seen,
                   right_seen, start_found, output ready);
endinterface

@@ rtl/tsef_csr.sv @@
// ----------------------------------------------------------------------------
// tsef_csr
// apb-style register file holding the search thresholds
// ----------------------------------------------------------------------------
module tsef_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tsef_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tsef_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tsef_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output tsef_pkg::cfg_type                cfg
);

   tsef_pkg::cfg_type       cfg_ff, cfg_in;
   tsef_pkg::csr_index_type index;
   logic                    wr_en;

   assign index      = tsef_pkg::csr_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            tsef_pkg::CSR_MIN_TRACK_WIDTH: cfg_in.min_track_width = csr_pwdata[7:0];
            tsef_pkg::CSR_WHITE_LEVEL:     cfg_in.white_level     = csr_pwdata[7:0];
            tsef_pkg::CSR_BLACK_LEVEL:     cfg_in.black_level     = csr_pwdata[7:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         tsef_pkg::CSR_MIN_TRACK_WIDTH: csr_prdata = {24'd0, cfg_ff.min_track_width};
         tsef_pkg::CSR_WHITE_LEVEL:     csr_prdata = {24'd0, cfg_ff.white_level};
         tsef_pkg::CSR_BLACK_LEVEL:     csr_prdata = {24'd0, cfg_ff.black_level};
         default:                       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_track_width <= tsef_pkg::MIN_TRACK_WIDTH_RST;
         cfg_ff.white_level     <= tsef_pkg::WHITE_LEVEL_RST;
         cfg_ff.black_level     <= tsef_pkg::BLACK_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/tsef_row_search.sv @@
// ----------------------------------------------------------------------------
// tsef_row_search
// per-row edge search over a three-pixel window, one pixel per advance cycle
// ----------------------------------------------------------------------------
module tsef_row_search (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  tsef_pkg::req_item_type item,
   input  tsef_pkg::cfg_type      cfg,
   output logic                   result_valid,
   output tsef_pkg::rsp_item_type result
);

   logic [23:0] window_ff, window_in, window_cur;
   logic [7:0]  col_ff, col_in, col_cur;
   logic [7:0]  left_col_ff, left_col_in, left_col_cur;
   logic [7:0]  right_col_ff, right_col_in, right_col_cur;
   logic        left_hit_ff, left_hit_in, left_hit_cur;
   logic        right_hit_ff, right_hit_in, right_hit_cur;
   logic        done_ff, done_in, done_cur;

   logic [7:0]  p0, p1, p2, p3;
   logic [7:0]  lc, rc;
   logic        lh, rh, in_range, ok;
   logic signed [9:0] diff;

   // a new search clears everything before the pixel is looked at
   always_comb begin
      if (item.new_search) begin
         window_cur = '0; col_cur = '0; left_col_cur = '0; right_col_cur = '0;
         left_hit_cur = 1'b0; right_hit_cur = 1'b0; done_cur = 1'b0;
      end else begin
         window_cur = window_ff; col_cur = col_ff;
         left_col_cur = left_col_ff; right_col_cur = right_col_ff;
         left_hit_cur = left_hit_ff; right_hit_cur = right_hit_ff;
         done_cur = done_ff;
      end
   end

   always_comb begin
      p0 = item.pixel;
      p1 = window_cur[7:0];
      p2 = window_cur[15:8];
      p3 = window_cur[23:16];
      lh = left_hit_cur;
      lc = left_col_cur;
      rh = right_hit_cur;
      rc = right_col_cur;

      // white pair at the left border
      if (col_cur == tsef_pkg::LEFT_PAIR_COL && !lh &&
          p1 == cfg.white_level && p0 == cfg.white_level) begin
         lh = 1'b1;
         lc = tsef_pkg::LEFT_BORDER_EDGE;
      end
      // white pair at the right border overrides an earlier pattern edge
      if (col_cur == tsef_pkg::RIGHT_BORDER_COL &&
          p1 == cfg.white_level && p0 == cfg.white_level) begin
         rh = 1'b1;
         rc = tsef_pkg::RIGHT_BORDER_COL;
      end

      in_range = col_cur >= tsef_pkg::PATTERN_FIRST_COL && col_cur <= tsef_pkg::LAST_COL;
      if (in_range && !lh && p3 == cfg.black_level && p2 == cfg.black_level &&
          p1 == cfg.white_level && p0 == cfg.white_level) begin
         lh = 1'b1;
         lc = col_cur - tsef_pkg::PATTERN_OFFSET;
      end
      if (in_range && !rh && p3 == cfg.white_level && p2 == cfg.white_level &&
          p1 == cfg.black_level && p0 == cfg.black_level) begin
         rh = 1'b1;
         rc = col_cur - tsef_pkg::PATTERN_OFFSET;
      end

      diff = $signed({2'b00, rc}) - $signed({2'b00, lc});
      ok   = lh && rh && (diff > $signed({2'b00, cfg.min_track_width}));

      result_valid       = !done_cur && item.end_of_row;
      result.left_col    = lh ? lc : 8'd0;
      result.right_col   = rh ? rc : 8'd0;
      result.edge_row    = item.row_index;
      result.left_seen   = lh;
      result.right_seen  = rh;
      result.start_found = ok;

      // next state
      window_in    = window_cur;
      col_in       = col_cur;
      left_col_in  = left_col_cur;
      right_col_in = right_col_cur;
      left_hit_in  = left_hit_cur;
      right_hit_in = right_hit_cur;
      done_in      = done_cur;
      if (!done_cur) begin
         if (item.end_of_row) begin
            window_in = '0; col_in = '0; left_col_in = '0; right_col_in = '0;
            left_hit_in = 1'b0; right_hit_in = 1'b0;
            done_in = ok;
         end else begin
            window_in    = {window_cur[15:0], p0};
            col_in       = (col_cur != tsef_pkg::COL_MAX) ? col_cur + 8'd1 : col_cur;
            left_col_in  = lc;
            right_col_in = rc;
            left_hit_in  = lh;
            right_hit_in = rh;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         col_ff       <= '0;
         left_col_ff  <= '0;
         right_col_ff <= '0;
         left_hit_ff  <= 1'b0;
         right_hit_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else if (advance) begin
         window_ff    <= window_in;
         col_ff       <= col_in;
         left_col_ff  <= left_col_in;
         right_col_ff <= right_col_in;
         left_hit_ff  <= left_hit_in;
         right_hit_ff <= right_hit_in;
         done_ff      <= done_in;
      end
   end

endmodule

@@ rtl/track_start_edge_finder.sv @@
// ----------------------------------------------------------------------------
// track_start_edge_finder
// finds the left and right track edges of each image row and flags the row
// where the search for the track start succeeds
// ----------------------------------------------------------------------------
// Pixels enter as one beat per clock, rows in search order (bottom row first),
// and the block keeps that rate: a new pixel beat is taken every cycle as long
// as the result side keeps up. Each beat lands in an input register, is run
// through the window compare and edge state once the result register is free,
// and a row's result beat is then written into the result register. Only the
// row-ending pixel yields a result beat; after a row passes the width test the
// block drops pixels silently until a beat with new_search set. A stalled
// result register holds back the input register, which in turn drops req
// ready. Registers sit at byte addresses 0, 4 and 8: min_track_width (reset
// 10), white_level (reset 255), black_level (reset 0); write them only while
// no beat is in flight.
// ----------------------------------------------------------------------------
module track_start_edge_finder (
   input  logic                             clock,
   input  logic                             reset,
   tsef_req_if.sink                         req_chan,
   tsef_rsp_if.source                       rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tsef_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tsef_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tsef_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   tsef_pkg::cfg_type      cfg;
   tsef_pkg::req_item_type in_item_ff;
   tsef_pkg::rsp_item_type result, rsp_item_ff;
   logic                   in_valid_ff, in_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   result_valid;
   logic                   out_free;     // result register can take a beat
   logic                   advance;      // pixel in the input register is processed
   logic                   req_take;

   // register file
   tsef_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake plumbing: output register parts the two sides
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = advance && result_valid;
      end
   end

   // window compare and per-row edge state
   tsef_row_search u_row_search (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (in_item_ff),
      .cfg          (cfg),
      .result_valid (result_valid),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.pixel      <= req_chan.pixel;
         in_item_ff.row_index  <= req_chan.row_index;
         in_item_ff.end_of_row <= req_chan.end_of_row;
         in_item_ff.new_search <= req_chan.new_search;
      end
      if (out_free && advance && result_valid) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.left_col    = rsp_item_ff.left_col;
   assign rsp_chan.right_col   = rsp_item_ff.right_col;
   assign rsp_chan.edge_row    = rsp_item_ff.edge_row;
   assign rsp_chan.left_seen   = rsp_item_ff.left_seen;
   assign rsp_chan.right_seen  = rsp_item_ff.right_seen;
   assign rsp_chan.start_found = rsp_item_ff.start_found;

   // a result beat only ever follows a processed row-ending pixel
   a_rsp_from_row_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && result_valid))
      else $error("result beat without a processed row end");

   // a start row always has both edges
   a_start_has_edges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.start_found |-> rsp_item_ff.left_seen &&
                                                  rsp_item_ff.right_seen)
      else $error("start row reported without both edges");

   // the pipeline never stalls while the result register is empty
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_chan.ready)
      else $error("pixel beat refused with an empty result register");

endmodule

@@ dv/track_start_edge_finder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_start_edge_finder_test
// drives pixel rows into the edge finder through its valid/ready channels,
// predicts every row result in a cycle-free model of the edge search and
// compares each result beat field by field, under several register settings
// and idling mixes
// ----------------------------------------------------------------------------
module track_start_edge_finder_test;

   localparam int CLOCK_HIGH_NS          = 4;
   localparam int CLOCK_LOW_NS           = 4;
   localparam int RESET_CYCLES           = 4;
   // result register sits behind the input register that takes a row's last pixel
   localparam int DRAIN_CYCLES           = 8;
   localparam int LONG_HOLD_CYCLES       = 300;
   localparam int PIXELS_PER_PHASE       = 36;
   localparam int HOLD_ROWS              = 24;
   localparam int MAX_PRINTED_MISMATCHES = 40;
   localparam int TIMEOUT_NS             = 4_000_000;

   typedef logic [7:0] pixel_row_type[$];

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [tsef_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [tsef_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [tsef_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   tsef_req_if req_bus ();
   tsef_rsp_if rsp_bus ();

   track_start_edge_finder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #CLOCK_LOW_NS clock = 1'b1;
      #CLOCK_HIGH_NS clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // edge search prediction: own copy of the registers and of the row state
   // --------------------------------------------------------------------------
   tsef_pkg::cfg_type csr_shadow = '{tsef_pkg::MIN_TRACK_WIDTH_RST,
                                     tsef_pkg::WHITE_LEVEL_RST,
                                     tsef_pkg::BLACK_LEVEL_RST};
   logic [23:0]  window;          // last three pixels, newest in the low byte
   logic [7:0]   next_col;        // column of the next pixel, saturating
   logic [7:0]   left_pos;
   logic [7:0]   right_pos;
   logic         left_found;
   logic         right_found;
   logic         start_done;      // start row found, pixels dropped until new search
   tsef_pkg::rsp_item_type row_results[$];  // expected row results, oldest first

   int pixels_sent = 0;           // pixel beats accepted by the block
   int mismatches  = 0;

   // idling mix, in percent per cycle
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit long_hold_pending = 1'b0;

   task clear_row_state;
      window      = '0;
      next_col    = '0;
      left_pos    = '0;
      right_pos   = '0;
      left_found  = 1'b0;
      right_found = 1'b0;
   endtask

   task predict_pixel(input tsef_pkg::req_item_type beat);
      logic [7:0]             newest;
      logic [7:0]             middle;
      logic [7:0]             oldest;
      logic [7:0]             wh;
      logic [7:0]             bl;
      int                     track_width;
      tsef_pkg::rsp_item_type row_result;
      if (beat.new_search) begin
         start_done = 1'b0;
         clear_row_state();
      end
      // search over: the beat is swallowed
      if (start_done) return;
      newest = window[7:0];
      middle = window[15:8];
      oldest = window[23:16];
      wh     = csr_shadow.white_level;
      bl     = csr_shadow.black_level;
      // white pair at columns 1 and 2 puts the left edge on the border
      if (next_col == tsef_pkg::LEFT_PAIR_COL && !left_found && newest == wh
          && beat.pixel == wh) begin
         left_found = 1'b1;
         left_pos   = tsef_pkg::LEFT_BORDER_EDGE;
      end
      // white pair at the right border wins over any earlier pattern edge
      if (next_col == tsef_pkg::RIGHT_BORDER_COL && newest == wh && beat.pixel == wh) begin
         right_found = 1'b1;
         right_pos   = tsef_pkg::RIGHT_BORDER_COL;
      end
      // four-pixel patterns, only inside the image width
      if (next_col >= tsef_pkg::PATTERN_FIRST_COL && next_col <= tsef_pkg::LAST_COL) begin
         if (!left_found && oldest == bl && middle == bl && newest == wh
             && beat.pixel == wh) begin
            left_found = 1'b1;
            left_pos   = next_col - tsef_pkg::PATTERN_OFFSET;
         end
         if (!right_found && oldest == wh && middle == wh && newest == bl
             && beat.pixel == bl) begin
            right_found = 1'b1;
            right_pos   = next_col - tsef_pkg::PATTERN_OFFSET;
         end
      end
      window = {window[15:0], beat.pixel};
      if (next_col != tsef_pkg::COL_MAX) next_col++;
      if (beat.end_of_row) begin
         track_width            = int'(right_pos) - int'(left_pos);
         row_result.left_col    = left_found ? left_pos : '0;
         row_result.right_col   = right_found ? right_pos : '0;
         row_result.edge_row    = beat.row_index;
         row_result.left_seen   = left_found;
         row_result.right_seen  = right_found;
         row_result.start_found = left_found && right_found
                                  && track_width > int'(csr_shadow.min_track_width);
         if (row_result.start_found) start_done = 1'b1;
         row_results.push_back(row_result);
         clear_row_state();
      end
   endtask

   // --------------------------------------------------------------------------
   // pixel sender, register writes and row building
   // --------------------------------------------------------------------------
   // valid is only lowered for an idle cycle, so back-to-back beats keep it high
   task send_pixel(input tsef_pkg::req_item_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.pixel      <= beat.pixel;
      req_bus.row_index  <= beat.row_index;
      req_bus.end_of_row <= beat.end_of_row;
      req_bus.new_search <= beat.new_search;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pixels_sent++;
      predict_pixel(beat);
   endtask

   task send_row(input logic [7:0] row_idx, input bit fresh_search,
                 input pixel_row_type pixels);
      tsef_pkg::req_item_type beat;
      foreach (pixels[i]) begin
         beat.pixel      = pixels[i];
         beat.row_index  = row_idx;
         beat.end_of_row = (i == pixels.size() - 1);
         beat.new_search = fresh_search && (i == 0);
         send_pixel(beat);
      end
   endtask

   // black outside the bounds, white inside, with a share of random pixels
   function automatic pixel_row_type track_row(int len, int left_bound, int right_bound,
                                               int noise_pct);
      pixel_row_type pixels;
      for (int col = 0; col < len; col++) begin
         if ($urandom_range(99) < noise_pct) pixels.push_back(8'($urandom_range(255)));
         else if (col >= left_bound && col <= right_bound)
            pixels.push_back(csr_shadow.white_level);
         else pixels.push_back(csr_shadow.black_level);
      end
      return pixels;
   endfunction

   // setup cycle, access cycle, then a quiet cycle so psel never toggles in a step
   task csr_write(input tsef_pkg::csr_index_type idx, input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {{(tsef_pkg::CSR_DATA_W - 8){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         tsef_pkg::CSR_MIN_TRACK_WIDTH: csr_shadow.min_track_width = value;
         tsef_pkg::CSR_WHITE_LEVEL:     csr_shadow.white_level     = value;
         tsef_pkg::CSR_BLACK_LEVEL:     csr_shadow.black_level     = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task set_levels(input logic [7:0] min_width, input logic [7:0] white,
                   input logic [7:0] black);
      csr_write(tsef_pkg::CSR_MIN_TRACK_WIDTH, min_width);
      csr_write(tsef_pkg::CSR_WHITE_LEVEL, white);
      csr_write(tsef_pkg::CSR_BLACK_LEVEL, black);
   endtask

   // stop sending, collect every outstanding row and let the pipe run dry;
   // pixels that end no row may still be in flight when the queue empties
   task drain_results;
      req_bus.valid <= 1'b0;
      while (row_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // result side: ready pattern with an optional long hold-off
   // --------------------------------------------------------------------------
   initial begin
      int held;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            for (held = 0; held < LONG_HOLD_CYCLES; held++) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED_MISMATCHES) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task check_field(input string name, input logic [7:0] row_idx, input logic [7:0] got,
                    input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("row %0d %s: got %0d expected %0d", row_idx, name, got, want));
   endtask

   // every result beat against the oldest expected row
   always @(posedge clock) begin
      tsef_pkg::rsp_item_type expected_row;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (row_results.size() == 0) begin
            report_mismatch($sformatf("result beat for row %0d with no row pending",
                                      rsp_bus.edge_row));
         end else begin
            expected_row = row_results.pop_front();
            check_field("left_col", expected_row.edge_row, rsp_bus.left_col,
                        expected_row.left_col);
            check_field("right_col", expected_row.edge_row, rsp_bus.right_col,
                        expected_row.right_col);
            check_field("edge_row", expected_row.edge_row, rsp_bus.edge_row,
                        expected_row.edge_row);
            check_field("left_seen", expected_row.edge_row, 8'(rsp_bus.left_seen),
                        8'(expected_row.left_seen));
            check_field("right_seen", expected_row.edge_row, 8'(rsp_bus.right_seen),
                        8'(expected_row.right_seen));
            check_field("start_found", expected_row.edge_row, 8'(rsp_bus.start_found),
                        8'(expected_row.start_found));
         end
      end
   end

   // --------------------------------------------------------------------------
   // tests
   // --------------------------------------------------------------------------
   // reset levels: a one-pixel row, a row too narrow to pass, one that passes
   task test_short_rows;
      send_row(8'd255, 1'b1, track_row(1, 0, 0, 100));
      send_row(8'd0, 1'b0, track_row(12, 3, 9, 0));
      send_row(8'd1, 1'b0, track_row(16, 3, 13, 0));
      drain_results();
   endtask

   // rows after a start row are dropped; new search restarts at column 0,
   // where a black-black-white-white run at column 0 is not a left edge
   task test_search_done;
      send_row(8'd2, 1'b0, track_row(8, 1, 5, 0));
      send_row(8'd3, 1'b1, track_row(10, 2, 7, 0));
      drain_results();
   endtask

   // full-width row: left edge on the border, right pattern edge replaced by
   // the white pair at the right border
   task test_border_edges;
      pixel_row_type pixels;
      pixels = track_row(tsef_pkg::IMAGE_WIDTH, 0, 60, 0);
      pixels[tsef_pkg::IMAGE_WIDTH - 3] = csr_shadow.white_level;
      pixels[tsef_pkg::IMAGE_WIDTH - 2] = csr_shadow.white_level;
      send_row(8'd10, 1'b1, pixels);
      drain_results();
   endtask

   // row longer than the column counter: patterns past the image width and
   // past counter saturation must never be seen
   task test_long_row;
      send_row(8'd128, 1'b1, track_row(270, 258, 264, 0));
      drain_results();
   endtask

   // white and black set to the same value, then to swapped reset values: the compares take them literally
   task test_equal_levels;
      set_levels(8'd0, 8'h5A, 8'h5A);
      send_row(8'd20, 1'b1, track_row(6, 0, 5, 0));
      drain_results();
      set_levels(8'd0, 8'd0, 8'd255);
      send_row(8'd21, 1'b1, track_row(24, 4, 20, 0));
      drain_results();
   endtask

   // result side held off for a long stretch while one-pixel rows keep coming,
   // so the pipe fills and pixel ready must drop
   task test_result_backpressure;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      long_hold_pending = 1'b1;
      for (int n = 0; n < HOLD_ROWS; n++) send_row(8'(n), 1'b1, track_row(1, 0, 0, 100));
      drain_results();
   endtask

   // frames of short random rows: mostly track shapes, some black/white
   // scatter, some pure noise
   task test_random_rows(input int send_pct, input int stall_pct);
      int            first_sent;
      int            rows_in_frame;
      int            pick;
      int            len;
      int            left_bound;
      logic [7:0]    row_idx;
      pixel_row_type pixels;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      first_sent    = pixels_sent;
      while (pixels_sent - first_sent < PIXELS_PER_PHASE) begin
         rows_in_frame = $urandom_range(1, 4);
         row_idx       = 8'($urandom_range(255));
         for (int r = 0; r < rows_in_frame && pixels_sent - first_sent < PIXELS_PER_PHASE;
              r++) begin
            pick = $urandom_range(99);
            if (pick < 85) len = $urandom_range(4, 24);
            else           len = $urandom_range(1, 3);
            pick = $urandom_range(99);
            if (pick < 60) begin
               left_bound = $urandom_range(0, len / 2);
               pixels = track_row(len, left_bound, $urandom_range(left_bound, len + 1),
                                  $urandom_range(0, 8));
            end else if (pick < 85) begin
               pixels = {};
               repeat (len) pixels.push_back($urandom_range(1) ? csr_shadow.white_level
                                                               : csr_shadow.black_level);
            end else begin
               pixels = track_row(len, 0, -1, 100);
            end
            // now and then a new search lands in the middle of a frame
            send_row(row_idx, r == 0 || $urandom_range(99) < 3, pixels);
            row_idx--;
         end
      end
      drain_results();
   endtask

   // --------------------------------------------------------------------------
   // run
   // --------------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.pixel      = '0;
      req_bus.row_index  = '0;
      req_bus.end_of_row = 1'b0;
      req_bus.new_search = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      clear_row_state();
      start_done = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_rows();
      test_search_done();
      test_border_edges();
      test_long_row();
      test_equal_levels();
      test_result_backpressure();

      set_levels(8'd0, 8'd255, 8'd0);
      test_random_rows(0, 0);
      set_levels(8'($urandom_range(0, 40)), 8'($urandom_range(255)), 8'($urandom_range(255)));
      test_random_rows(83, 0);
      set_levels(8'd255, 8'd0, 8'd255);
      test_random_rows(0, 83);
      set_levels(8'($urandom_range(0, 40)), 8'($urandom_range(255)), 8'($urandom_range(255)));
      test_random_rows(8, 8);

      if (mismatches == 0 && row_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      #TIMEOUT_NS;
      $display("simulation failed");
      $finish;
   end

endmodule

@@ track_start_edge_finder.f @@
rtl/tsef_pkg.sv
rtl/tsef_if.sv
rtl/tsef_csr.sv
rtl/tsef_row_search.sv
rtl/track_start_edge_finder.sv
dv/track_start_edge_finder_test.sv
